[design/bilinear_form_mac_defines.svh]
// Assertion macros for the bilinear form MAC.
`ifndef BILINEAR_FORM_MAC_DEFINES_SVH
`define BILINEAR_FORM_MAC_DEFINES_SVH
`ifndef SYNTHESIS
`define BFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BFM_ASSERT(lbl, prop, msg)
`define BFM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[design/bfm_pkg.sv]
`timescale 1ns / 1ps
package bfm_pkg;

  localparam int IDX_W          = 6;
  localparam int VAL_W          = 16;
  localparam int CFG_W          = 7;
  localparam int REQ_W          = 2;
  localparam int ROW_W          = 40;
  localparam int TOT_W          = 48;
  localparam int PROD_W         = 2 * VAL_W;
  localparam int PROD2_W        = ROW_W + VAL_W;
  localparam int FRAC_SHIFT     = 15;
  localparam int DEF_MAX_LENGTH = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_W-1:0] LENGTH_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_LOAD_X = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_Y = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MATRIX = 2'd2;

  localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
  localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};
  localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD_X,
    CMD_LOAD_Y,
    CMD_MAT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
    logic                    last;
  } cmd_t;

endpackage

[design/bfm_front.sv]
`timescale 1ns / 1ps
module bfm_front #(
  parameter int MAX_LENGTH = bfm_pkg::DEF_MAX_LENGTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bfm_pkg::REQ_W-1:0]         req_type_i,
  input  logic [bfm_pkg::IDX_W-1:0]         row_index_i,
  input  logic [bfm_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [bfm_pkg::VAL_W-1:0]  element_value_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output bfm_pkg::cmd_t                     q_cmd_o
);

  localparam int LW = ($clog2(MAX_LENGTH + 1) > bfm_pkg::CFG_W) ?
                      $clog2(MAX_LENGTH + 1) : bfm_pkg::CFG_W;

  logic [bfm_pkg::CFG_W-1:0] length_q;
  logic [LW-1:0]             len_w;
  logic [LW-1:0]             len_eff;
  logic [LW-1:0]             last_idx;
  logic [LW-1:0]             row_w;
  logic [LW-1:0]             col_w;
  logic                      keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= bfm_pkg::LENGTH_RESET;
    end else if (cfg_we_i) begin
      length_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    len_w = LW'(length_q);
    if (len_w == '0) begin
      len_eff = LW'(1);
    end else if (len_w > LW'(MAX_LENGTH)) begin
      len_eff = LW'(MAX_LENGTH);
    end else begin
      len_eff = len_w;
    end
    last_idx = len_eff - LW'(1);
    row_w    = LW'(row_index_i);
    col_w    = LW'(col_index_i);

    keep            = 1'b0;
    q_cmd_o.kind    = bfm_pkg::CMD_MAT;
    q_cmd_o.row     = row_index_i;
    q_cmd_o.col     = col_index_i;
    q_cmd_o.value   = element_value_i;
    q_cmd_o.row_end = (col_w == last_idx);
    q_cmd_o.last    = (col_w == last_idx) && (row_w == last_idx);
    case (req_type_i)
      bfm_pkg::REQ_LOAD_X: begin
        q_cmd_o.kind = bfm_pkg::CMD_LOAD_X;
        keep         = col_w < LW'(MAX_LENGTH);
      end
      bfm_pkg::REQ_LOAD_Y: begin
        q_cmd_o.kind = bfm_pkg::CMD_LOAD_Y;
        keep         = row_w < LW'(MAX_LENGTH);
      end
      bfm_pkg::REQ_MATRIX: begin
        q_cmd_o.kind = bfm_pkg::CMD_MAT;
        keep         = (row_w < len_eff) && (col_w < len_eff);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // dropped requests are still taken, just never queued
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

[design/bfm_queue.sv]
`timescale 1ns / 1ps
module bfm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfm_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bfm_pkg::cmd_t cmd_o
);

  localparam int PW = (bfm_pkg::QUEUE_DEPTH > 1) ? $clog2(bfm_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(bfm_pkg::QUEUE_DEPTH + 1);

  bfm_pkg::cmd_t mem_q [bfm_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(bfm_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(bfm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(bfm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[design/bfm_back.sv]
`timescale 1ns / 1ps
`include "bilinear_form_mac_defines.svh"
module bfm_back #(
  parameter int MAX_LENGTH = bfm_pkg::DEF_MAX_LENGTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  bfm_pkg::cmd_t                     q_cmd_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bfm_pkg::TOT_W-1:0]  result_value_o,
  output logic                              overflow_o
);

  localparam int AW   = $clog2(MAX_LENGTH);
  localparam int IW   = (AW > bfm_pkg::IDX_W) ? AW : bfm_pkg::IDX_W;
  localparam int RS_W = bfm_pkg::ROW_W + 1;
  localparam int TS_W = bfm_pkg::TOT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_ACC,
    ST_MUL2,
    ST_TOT
  } state_e;

  state_e state_q;

  logic signed [bfm_pkg::VAL_W-1:0]   x_mem [MAX_LENGTH];
  logic signed [bfm_pkg::VAL_W-1:0]   y_mem [MAX_LENGTH];
  logic signed [bfm_pkg::VAL_W-1:0]   x_rd_q;
  logic signed [bfm_pkg::VAL_W-1:0]   y_rd_q;
  logic signed [bfm_pkg::VAL_W-1:0]   val_q;
  logic                               row_end_q;
  logic                               last_q;
  logic signed [bfm_pkg::PROD_W-1:0]  prod_q;
  logic signed [bfm_pkg::PROD2_W-1:0] prod2_q;
  logic signed [bfm_pkg::ROW_W-1:0]   row_acc_q;
  logic signed [bfm_pkg::TOT_W-1:0]   total_q;
  logic                               ovf_q;
  logic                               out_valid_q;
  logic signed [bfm_pkg::TOT_W-1:0]   result_q;
  logic                               out_ovf_q;

  logic [IW-1:0]                      row_w;
  logic [IW-1:0]                      col_w;
  logic [AW-1:0]                      row_addr;
  logic [AW-1:0]                      col_addr;
  logic signed [RS_W-1:0]             row_sum;
  logic                               row_ovf;
  logic signed [bfm_pkg::ROW_W-1:0]   row_next;
  logic signed [bfm_pkg::PROD2_W-1:0] prod2_sh;
  logic signed [TS_W-1:0]             tot_sum;
  logic                               tot_ovf;
  logic signed [bfm_pkg::TOT_W-1:0]   tot_next;
  logic                               out_free;

  assign row_w    = IW'(q_cmd_i.row);
  assign col_w    = IW'(q_cmd_i.col);
  assign row_addr = row_w[AW-1:0];
  assign col_addr = col_w[AW-1:0];
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign out_free = !out_valid_q || out_ready_i;

  // saturating row and total adders
  always_comb begin
    row_sum  = RS_W'(row_acc_q) + RS_W'(prod_q);
    row_ovf  = row_sum[RS_W-1] != row_sum[RS_W-2];
    row_next = row_ovf ? (row_sum[RS_W-1] ? bfm_pkg::ROW_MIN : bfm_pkg::ROW_MAX)
                       : row_sum[bfm_pkg::ROW_W-1:0];
    prod2_sh = prod2_q >>> bfm_pkg::FRAC_SHIFT;
    tot_sum  = TS_W'(total_q) + TS_W'(prod2_sh);
    tot_ovf  = tot_sum[TS_W-1] != tot_sum[TS_W-2];
    tot_next = tot_ovf ? (tot_sum[TS_W-1] ? bfm_pkg::TOT_MIN : bfm_pkg::TOT_MAX)
                       : tot_sum[bfm_pkg::TOT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cmd_i.kind == bfm_pkg::CMD_LOAD_X) begin
      x_mem[col_addr] <= q_cmd_i.value;
    end
    if (q_pop_o && q_cmd_i.kind == bfm_pkg::CMD_LOAD_Y) begin
      y_mem[row_addr] <= q_cmd_i.value;
    end
    if (q_pop_o && q_cmd_i.kind == bfm_pkg::CMD_MAT) begin
      x_rd_q <= x_mem[col_addr];
      y_rd_q <= y_mem[row_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      val_q     <= q_cmd_i.value;
      row_end_q <= q_cmd_i.row_end;
      last_q    <= q_cmd_i.last;
    end
    if (state_q == ST_MUL1) begin
      prod_q <= val_q * x_rd_q;
    end
    if (state_q == ST_MUL2) begin
      prod2_q <= row_acc_q * y_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_acc_q   <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o && q_cmd_i.kind == bfm_pkg::CMD_MAT) begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          row_acc_q <= row_next;
          if (row_ovf) begin
            ovf_q <= 1'b1;
          end
          state_q <= row_end_q ? ST_MUL2 : ST_IDLE;
        end
        ST_MUL2: begin
          state_q <= ST_TOT;
        end
        ST_TOT: begin
          if (!last_q) begin
            total_q   <= tot_next;
            ovf_q     <= ovf_q || tot_ovf;
            row_acc_q <= '0;
            state_q   <= ST_IDLE;
          end else if (out_free) begin
            result_q    <= tot_next;
            out_ovf_q   <= ovf_q || tot_ovf;
            out_valid_q <= 1'b1;
            total_q     <= '0;
            ovf_q       <= 1'b0;
            row_acc_q   <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign overflow_o     = out_ovf_q;

  `BFM_ASSERT(a_mat_starts, (q_pop_o && q_cmd_i.kind == bfm_pkg::CMD_MAT) |=> state_q == ST_MUL1, "matrix transfer did not start multiply")
  `BFM_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(state_q == ST_TOT && last_q), "result raised outside final element")
  `BFM_ASSERT(a_clear_after_result, $rose(out_valid_q) |-> (total_q == '0 && !ovf_q), "total not cleared after result")
  `BFM_ASSERT(a_row_cleared, (state_q == ST_TOT ##1 state_q == ST_IDLE) |-> row_acc_q == '0, "row sum not cleared at row end")
  `BFM_ASSERT_ALWAYS(a_reset_idle, (!rst_ni && $past(!rst_ni)) |-> (state_q == ST_IDLE && !out_valid_q), "not idle in reset")

endmodule

[design/bilinear_form_mac.sv]
`timescale 1ns / 1ps
// Bilinear form MAC: returns y' * (A * x) in Q.30, saturated to 48 bits, with a sticky
// overflow flag. Load x and y first (req_type 0 and 1), then stream A in row-major order
// (req_type 2); the element at row = col = length-1 emits one result and clears the sums.
// A front end classifies and drops out-of-range or unknown requests and feeds a 2-entry
// command queue; the back-end sequencer steps each matrix element through read, multiply
// and accumulate, and a row-ending element also through the second multiply and total
// update; the final element waits there while the result register is still held by the
// consumer. Vector loads are written as they are popped; dropped requests are never queued.
module bilinear_form_mac #(
  parameter int MAX_LENGTH = bfm_pkg::DEF_MAX_LENGTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bfm_pkg::REQ_W-1:0]         req_type_i,
  input  logic [bfm_pkg::IDX_W-1:0]         row_index_i,
  input  logic [bfm_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [bfm_pkg::VAL_W-1:0]  element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bfm_pkg::TOT_W-1:0]  result_value_o,
  output logic                              overflow_o
);

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  bfm_pkg::cmd_t push_cmd;
  bfm_pkg::cmd_t head_cmd;

  bfm_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  bfm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .cmd_o  (head_cmd)
  );

  bfm_back #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .overflow_o    (overflow_o)
  );

endmodule

[verif/bilinear_form_mac_tb.sv]
`timescale 1ns / 1ps
module bilinear_form_mac_tb;

  localparam logic [bfm_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_LEN       = bfm_pkg::DEF_MAX_LENGTH;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 400;

  class bilinear_scoreboard;
    typedef struct packed {
      logic signed [bfm_pkg::TOT_W-1:0] value;
      logic                             ovf;
    } total_t;

    logic signed [bfm_pkg::VAL_W-1:0] x_store [MAX_LEN];
    logic signed [bfm_pkg::VAL_W-1:0] y_store [MAX_LEN];
    bit                               x_written [MAX_LEN];
    bit                               y_written [MAX_LEN];
    longint                           row_sum;
    longint                           total_sum;
    bit                               sat_seen;
    int                               length_eff;
    total_t                           expected_totals [$];
    int                               errors;

    function new();
      row_sum     = 0;
      total_sum   = 0;
      sat_seen    = 0;
      length_eff  = MAX_LEN;
      errors      = 0;
      foreach (x_written[k]) begin
        x_written[k] = 0;
        y_written[k] = 0;
      end
    endfunction

    function void set_length(logic [bfm_pkg::CFG_W-1:0] v);
      if (v == 0) length_eff = 1;
      else if (v > MAX_LEN) length_eff = MAX_LEN;
      else length_eff = int'(v);
    endfunction

    function longint saturate(longint v, longint hi, longint lo);
      if (v > hi) begin
        sat_seen = 1;
        return hi;
      end
      if (v < lo) begin
        sat_seen = 1;
        return lo;
      end
      return v;
    endfunction

    // returns 1 when the transfer does something
    function bit note_transfer(logic [bfm_pkg::REQ_W-1:0] kind, logic [bfm_pkg::IDX_W-1:0] row,
                               logic [bfm_pkg::IDX_W-1:0] col,
                               logic signed [bfm_pkg::VAL_W-1:0] val);
      longint scaled;
      total_t t;
      case (kind)
        bfm_pkg::REQ_LOAD_X: begin
          x_store[col]   = val;
          x_written[col] = 1;
          return 1;
        end
        bfm_pkg::REQ_LOAD_Y: begin
          y_store[row]   = val;
          y_written[row] = 1;
          return 1;
        end
        bfm_pkg::REQ_MATRIX: begin
          if (row >= length_eff || col >= length_eff) return 0;
          row_sum = saturate(row_sum + longint'(val) * longint'(x_store[col]),
                             longint'(bfm_pkg::ROW_MAX), longint'(bfm_pkg::ROW_MIN));
          if (col == length_eff - 1) begin
            scaled    = (row_sum * longint'(y_store[row])) >>> bfm_pkg::FRAC_SHIFT;
            total_sum = saturate(total_sum + scaled, longint'(bfm_pkg::TOT_MAX),
                                 longint'(bfm_pkg::TOT_MIN));
            row_sum   = 0;
            if (row == length_eff - 1) begin
              t.value = total_sum[bfm_pkg::TOT_W-1:0];
              t.ovf   = sat_seen;
              expected_totals.push_back(t);
              total_sum = 0;
              sat_seen  = 0;
            end
          end
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("ERROR @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_total(logic signed [bfm_pkg::TOT_W-1:0] value, logic ovf);
      total_t t;
      if (expected_totals.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d ovf %0d", value, ovf));
      end else begin
        t = expected_totals.pop_front();
        if (value !== t.value)
          report_mismatch($sformatf("result %0d, expected %0d", value, t.value));
        if (ovf !== t.ovf)
          report_mismatch($sformatf("overflow %0d, expected %0d", ovf, t.ovf));
      end
    endtask
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [bfm_pkg::CFG_W-1:0]        cfg_wdata_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [bfm_pkg::REQ_W-1:0]        req_type_i;
  logic [bfm_pkg::IDX_W-1:0]        row_index_i;
  logic [bfm_pkg::IDX_W-1:0]        col_index_i;
  logic signed [bfm_pkg::VAL_W-1:0] element_value_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic signed [bfm_pkg::TOT_W-1:0] result_value_o;
  logic                             overflow_o;

  bilinear_form_mac u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .overflow_o      (overflow_o)
  );

  bilinear_scoreboard sb = new();
  bit send_calm;
  int used_items;
  int cycles;
  int length_plan [12] = '{1, 0, 2, 127, 3, 64, 4, 2, 5, 1, 8, 3};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_total(result_value_o, overflow_o);
  end

  // result side back-pressure
  initial begin
    int stall;
    int roll;
    bit calm;
    stall = 0;
    calm  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        roll = $urandom_range(0, 99);
        if (!calm && roll < 30) stall = $urandom_range(1, 3);
        else if (!calm && roll < 35) stall = $urandom_range(20, 60);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if ($urandom_range(0, 79) == 0) send_calm = !send_calm;
    if (send_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [bfm_pkg::VAL_W-1:0] rand_value();
    logic [bfm_pkg::VAL_W-1:0] raw;
    case ($urandom_range(0, 9))
      0: return bfm_pkg::VAL_W'(-32768);
      1: return bfm_pkg::VAL_W'(32767);
      2: return '0;
      3: return '1;
      default: begin
        raw = bfm_pkg::VAL_W'($urandom);
        return raw;
      end
    endcase
  endfunction

  task automatic send_req(input logic [bfm_pkg::REQ_W-1:0] kind, input int row, input int col,
                          input logic signed [bfm_pkg::VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    row_index_i     <= row[bfm_pkg::IDX_W-1:0];
    col_index_i     <= col[bfm_pkg::IDX_W-1:0];
    element_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_transfer(kind, row[bfm_pkg::IDX_W-1:0], col[bfm_pkg::IDX_W-1:0], val))
      used_items++;
  endtask

  // loads any vector entry the element will read that was never written
  task automatic send_matrix(input int row, input int col,
                             input logic signed [bfm_pkg::VAL_W-1:0] val);
    int n;
    n = sb.length_eff;
    if (row < n && col < n) begin
      if (!sb.x_written[col])
        send_req(bfm_pkg::REQ_LOAD_X, $urandom_range(0, 63), col, rand_value());
      if (col == n - 1 && !sb.y_written[row])
        send_req(bfm_pkg::REQ_LOAD_Y, row, $urandom_range(0, 63), rand_value());
    end
    send_req(bfm_pkg::REQ_MATRIX, row, col, val);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_totals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [bfm_pkg::CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_length(v);
  endtask

  // occasional reloads, unknown requests and out-of-range elements
  task automatic sprinkle();
    int n;
    n = sb.length_eff;
    if ($urandom_range(0, 99) >= 8) return;
    case ($urandom_range(0, 3))
      0: send_req(bfm_pkg::REQ_LOAD_X, $urandom_range(0, 63), $urandom_range(0, 63),
                  rand_value());
      1: send_req(bfm_pkg::REQ_LOAD_Y, $urandom_range(0, 63), $urandom_range(0, 63),
                  rand_value());
      2: send_req(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
      default: begin
        if (n < MAX_LEN) begin
          if ($urandom_range(0, 1))
            send_req(bfm_pkg::REQ_MATRIX, $urandom_range(n, 63), $urandom_range(0, 63),
                     rand_value());
          else
            send_req(bfm_pkg::REQ_MATRIX, $urandom_range(0, 63), $urandom_range(n, 63),
                     rand_value());
        end else begin
          send_req(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
        end
      end
    endcase
  endtask

  task automatic run_set();
    int n;
    int r;
    int c;
    n = sb.length_eff;
    if (n <= 12) begin
      for (r = 0; r < n; r++) begin
        for (c = 0; c < n; c++) begin
          sprinkle();
          if ($urandom_range(0, 39) == 0 && !(r == n - 1 && c == n - 1)) continue;
          send_matrix(r, c, rand_value());
        end
      end
    end else begin
      // sparse pass for long vectors
      repeat ($urandom_range(4, 20)) begin
        sprinkle();
        r = $urandom_range(0, n - 1);
        c = ($urandom_range(0, 3) == 0) ? n - 1 : $urandom_range(0, n - 1);
        send_matrix(r, c, rand_value());
      end
      send_matrix(n - 1, n - 1, rand_value());
    end
  endtask

  initial begin
    logic [bfm_pkg::CFG_W-1:0] cfg;
    int                        phase;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    req_type_i      = bfm_pkg::REQ_LOAD_X;
    row_index_i     = '0;
    col_index_i     = '0;
    element_value_i = '0;
    send_calm       = 0;
    used_items      = 0;
    cycles          = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset length, then short length with extreme values
    send_req(bfm_pkg::REQ_LOAD_X, 0, 63, bfm_pkg::VAL_W'(-1));
    send_req(bfm_pkg::REQ_LOAD_Y, 63, 0, bfm_pkg::VAL_W'(12345));
    send_req(bfm_pkg::REQ_MATRIX, 63, 63, bfm_pkg::VAL_W'(-32768));
    wait_drained();
    write_length(bfm_pkg::CFG_W'(2));
    send_req(bfm_pkg::REQ_LOAD_X, 0, 0, bfm_pkg::VAL_W'(-32768));
    send_req(bfm_pkg::REQ_LOAD_X, 5, 1, bfm_pkg::VAL_W'(32767));
    send_req(bfm_pkg::REQ_LOAD_Y, 0, 9, bfm_pkg::VAL_W'(-32768));
    send_req(bfm_pkg::REQ_LOAD_Y, 1, 0, bfm_pkg::VAL_W'(32767));
    send_req(REQ_UNUSED, 63, 63, bfm_pkg::VAL_W'(-1));
    send_req(bfm_pkg::REQ_MATRIX, 2, 0, bfm_pkg::VAL_W'(1234));
    send_req(bfm_pkg::REQ_MATRIX, 0, 63, bfm_pkg::VAL_W'(-1234));
    send_req(bfm_pkg::REQ_MATRIX, 0, 0, bfm_pkg::VAL_W'(-32768));
    send_req(bfm_pkg::REQ_MATRIX, 0, 1, bfm_pkg::VAL_W'(32767));
    send_req(bfm_pkg::REQ_MATRIX, 1, 0, bfm_pkg::VAL_W'(0));
    send_req(bfm_pkg::REQ_MATRIX, 1, 1, bfm_pkg::VAL_W'(-1));
    send_req(bfm_pkg::REQ_MATRIX, 1, 1, bfm_pkg::VAL_W'(32767));
    send_req(bfm_pkg::REQ_MATRIX, 0, 1, bfm_pkg::VAL_W'(-1));
    send_req(bfm_pkg::REQ_MATRIX, 1, 1, bfm_pkg::VAL_W'(1));

    phase = 0;
    used_items = 0;
    while (used_items < RANDOM_ITEMS) begin
      if (phase < 12) begin
        cfg = bfm_pkg::CFG_W'(length_plan[phase]);
      end else begin
        case ($urandom_range(0, 19))
          0: cfg = bfm_pkg::CFG_W'($urandom_range(13, 127));
          1: cfg = '0;
          2, 3: cfg = bfm_pkg::CFG_W'($urandom_range(7, 12));
          default: cfg = bfm_pkg::CFG_W'($urandom_range(1, 6));
        endcase
      end
      wait_drained();
      write_length(cfg);
      repeat ($urandom_range(1, 3)) run_set();
      phase++;
    end

    wait_drained();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/bfm_pkg.sv
design/bfm_front.sv
design/bfm_queue.sv
design/bfm_back.sv
design/bilinear_form_mac.sv
verif/bilinear_form_mac_tb.sv
